// File: src/imu_tilt_complementary_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Tilt filter assertion macros
// Shared concurrent assertion forms for the tilt filter RTL.
// ----------------------------------------------------------------------------
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_CORE_DEFINES_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define ITCF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ITCF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/itcf_pkg.sv
// ----------------------------------------------------------------------------
// Tilt filter package
// Widths, register codes, status types and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package itcf_pkg;

  // Tuning constants
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 16;

  // Field widths
  localparam int IN_W       = 16;
  localparam int ANG_W      = 26;
  localparam int GAIN_W     = 24;
  localparam int WEIGHT_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT    = 2'd1;
  localparam logic [GAIN_W-1:0]    GAIN_RESET         = 24'd327860;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET       = 17'd64225;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_ONE         = 17'h10000;

  // Arctangent table and CORDIC sizing
  localparam int TABLE_LEN  = 24;
  localparam int TABLE_FRAC = 24;
  localparam int GUARD      = 6;
  localparam int CORD_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int TAB_IW     = $clog2(TABLE_LEN);

  // Square root sizing: radicand is the sum of squares scaled by 2^16
  localparam int SQ_W    = 2 * IN_W;
  localparam int RAD_SH  = 16;
  localparam int SQ_IN_W = SQ_W + RAD_SH;
  localparam int ROOT_W  = SQ_IN_W / 2;
  localparam int SQ_CYC  = ROOT_W / 2;

  // CORDIC datapath widths
  localparam int NUM_SH = 8 + GUARD;
  localparam int X_W    = ROOT_W + GUARD + 4;
  localparam int Z_W    = 33;
  localparam int RND_SH = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int ACC_W  = Z_W - RND_SH + 1;

  // Gyro increment and blend widths
  localparam int GS       = 32 - ANGLE_FRAC_BITS;
  localparam int INC_W    = IN_W + GAIN_W + 2 - GS;
  localparam int PRED_W   = ((ANG_W > INC_W) ? ANG_W : INC_W) + 1;
  localparam int MA_W     = (PRED_W > ACC_W) ? PRED_W : ACC_W;
  localparam int MB_W     = GAIN_W + 1;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int BLEND_SH = 16;

  // Control into and status out of the angle unit
  typedef struct packed {
    logic start;
  } ang_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ang_sts_t;

  // atan(2^-i) in degrees, Q.24
  function automatic logic [Z_W-1:0] atan_tab(input logic [TAB_IW-1:0] idx);
    logic [Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = Z_W'(754974720);
      5'd1:    v = Z_W'(445687602);
      5'd2:    v = Z_W'(235489088);
      5'd3:    v = Z_W'(119537938);
      5'd4:    v = Z_W'(60000934);
      5'd5:    v = Z_W'(30029717);
      5'd6:    v = Z_W'(15018523);
      5'd7:    v = Z_W'(7509720);
      5'd8:    v = Z_W'(3754917);
      5'd9:    v = Z_W'(1877466);
      5'd10:   v = Z_W'(938734);
      5'd11:   v = Z_W'(469367);
      5'd12:   v = Z_W'(234684);
      5'd13:   v = Z_W'(117342);
      5'd14:   v = Z_W'(58671);
      5'd15:   v = Z_W'(29335);
      5'd16:   v = Z_W'(14668);
      5'd17:   v = Z_W'(7334);
      5'd18:   v = Z_W'(3667);
      5'd19:   v = Z_W'(1833);
      5'd20:   v = Z_W'(917);
      5'd21:   v = Z_W'(458);
      5'd22:   v = Z_W'(229);
      5'd23:   v = Z_W'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/itcf_if.sv
// ----------------------------------------------------------------------------
// Tilt filter channel interfaces
// Sample input, angle output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface itcf_in_if;
  import itcf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] accel_x;
  logic signed [IN_W-1:0] accel_y;
  logic signed [IN_W-1:0] accel_z;
  logic signed [IN_W-1:0] gyro_x;
  logic signed [IN_W-1:0] gyro_y;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y,
                output ready);
endinterface

interface itcf_out_if;
  import itcf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] pitch_angle;
  logic signed [ANG_W-1:0] roll_angle;
  logic                    saturated;
  modport source (output valid, pitch_angle, roll_angle, saturated, input ready);
  modport sink (input valid, pitch_angle, roll_angle, saturated, output ready);
endinterface

interface itcf_cfg_if;
  import itcf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/itcf_angle.sv
// ----------------------------------------------------------------------------
// Tilt filter angle unit
// Integer square root (two bits a cycle) then CORDIC vectoring, one step a
// cycle, giving atan2(num, sqrt(radicand) / 256) in degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module itcf_angle (
  input  logic                                clk,
  input  logic                                rst,
  input  itcf_pkg::ang_ctl_t                  ctl,
  input  logic [itcf_pkg::SQ_IN_W-1:0]        radicand,
  input  logic signed [itcf_pkg::IN_W-1:0]    num,
  output itcf_pkg::ang_sts_t                  sts,
  output logic signed [itcf_pkg::ACC_W-1:0]   angle
);
  import itcf_pkg::*;

  localparam int CNT_W = ($clog2(SQ_CYC) > TAB_IW) ? $clog2(SQ_CYC) : TAB_IW;
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(SQ_CYC - 1);
  localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORD_ITERS - 1);
  localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(2 ** (RND_SH - 1));

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_SQRT = 2'd1;
  localparam logic [1:0] U_CORD = 2'd2;
  localparam logic [1:0] U_RND  = 2'd3;

  logic [1:0]             state;
  logic [CNT_W-1:0]       cnt;
  logic                   done;
  logic [SQ_IN_W-1:0]     rad;
  logic [ROOT_W+1:0]      rem;
  logic [ROOT_W-1:0]      root;
  logic signed [IN_W-1:0] num_q;
  logic signed [X_W-1:0]  x;
  logic signed [X_W-1:0]  y;
  logic signed [Z_W-1:0]  z;
  logic                   zero_vec;

  logic [SQ_IN_W-1:0]     rad_a;
  logic [ROOT_W+1:0]      rem_a;
  logic [ROOT_W-1:0]      root_a;
  logic [ROOT_W+4:0]      trial;
  logic [TAB_IW-1:0]      sh;
  logic signed [X_W-1:0]  xs;
  logic signed [X_W-1:0]  ys;
  logic signed [X_W-1:0]  x_n;
  logic signed [X_W-1:0]  y_n;
  logic signed [Z_W-1:0]  z_n;
  logic signed [Z_W-1:0]  tab;
  logic signed [Z_W-1:0]  z_rnd;
  logic signed [Z_W-1:0]  z_sh;

  // Restoring square root: consume two radicand bit pairs per cycle
  always_comb begin
    rem_a  = rem;
    root_a = root;
    rad_a  = rad;
    trial  = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {1'b0, rem_a, rad_a[SQ_IN_W-1 -: 2]} - {3'b000, root_a, 2'b01};
      if (!trial[ROOT_W+4]) begin
        rem_a  = trial[ROOT_W+1:0];
        root_a = {root_a[ROOT_W-2:0], 1'b1};
      end else begin
        rem_a  = {rem_a[ROOT_W-1:0], rad_a[SQ_IN_W-1 -: 2]};
        root_a = {root_a[ROOT_W-2:0], 1'b0};
      end
      rad_a = {rad_a[SQ_IN_W-3:0], 2'b00};
    end
  end

  // CORDIC vectoring step: rotate toward y = 0
  always_comb begin
    sh  = cnt[TAB_IW-1:0];
    tab = $signed(atan_tab(sh));
    xs  = x >>> sh;
    ys  = y >>> sh;
    if (!y[X_W-1]) begin
      x_n = x + ys;
      y_n = y - xs;
      z_n = z + tab;
    end else begin
      x_n = x - ys;
      y_n = y + xs;
      z_n = z - tab;
    end
    z_rnd = z + Z_HALF;
    z_sh  = z_rnd >>> RND_SH;
  end

  // Sequence square root, rotations and final rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (ctl.start) begin
            rad   <= radicand;
            num_q <= num;
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= U_SQRT;
          end
        end
        U_SQRT: begin
          rad  <= rad_a;
          rem  <= rem_a;
          root <= root_a;
          cnt  <= cnt + 1'b1;
          if (cnt == SQ_LAST) begin
            x        <= $signed({{(X_W-ROOT_W-GUARD){1'b0}}, root_a, {GUARD{1'b0}}});
            y        <= $signed({{(X_W-IN_W-NUM_SH){num_q[IN_W-1]}}, num_q,
                                 {NUM_SH{1'b0}}});
            z        <= '0;
            zero_vec <= (root_a == '0) && (num_q == '0);
            cnt      <= '0;
            state    <= U_CORD;
          end
        end
        U_CORD: begin
          x   <= x_n;
          y   <= y_n;
          z   <= z_n;
          cnt <= cnt + 1'b1;
          if (cnt == CORD_LAST) begin
            cnt   <= '0;
            state <= U_RND;
          end
        end
        U_RND: begin
          angle <= zero_vec ? '0 : z_sh[ACC_W-1:0];
          done  <= 1'b1;
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign sts.busy = (state != U_IDLE);
  assign sts.done = done;

endmodule

`default_nettype wire

// File: src/imu_tilt_complementary_filter_core.sv
// ----------------------------------------------------------------------------
// Tilt complementary filter core
// Pitch and roll from raw accelerometer and gyro counts: gyro integration
// blended with accelerometer angles from a square root and CORDIC unit.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake     contents
//  samples   in   valid/ready   accel_x, accel_y, accel_z, gyro_x, gyro_y
//  angles    out  valid/ready   pitch_angle, roll_angle, saturated
//  cfg       in   valid/ready   index, data (register write, always ready)
//
//  Each sample runs the angle unit once for pitch and once for roll, each
//  pass a start, a square root, the CORDIC steps, a rounding step and a
//  handoff; one shared multiplier serves the gyro products and squares and
//  the blend, plus an accept step before and an output step after.
//  samples.ready is high only while no sample is in work; a result waiting
//  on angles holds the next sample at its last cycle.
//  Synchronous reset clears the estimates and loads the register defaults.
//
`default_nettype none

module imu_tilt_complementary_filter_core (
  input  logic        clk,
  input  logic        rst,
  itcf_in_if.sink     samples,
  itcf_out_if.source  angles,
  itcf_cfg_if.sink    cfg
);
  import itcf_pkg::*;

`include "imu_tilt_complementary_filter_core_defines.svh"

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRE   = 3'd1;
  localparam logic [2:0] S_ANG_P = 3'd2;
  localparam logic [2:0] S_ANG_R = 3'd3;
  localparam logic [2:0] S_BLEND = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Multiplier operations
  localparam logic [3:0] OP_GY_GAIN = 4'd0;
  localparam logic [3:0] OP_GX_GAIN = 4'd1;
  localparam logic [3:0] OP_AX_SQ   = 4'd2;
  localparam logic [3:0] OP_AY_SQ   = 4'd3;
  localparam logic [3:0] OP_AZ_SQ   = 4'd4;
  localparam logic [3:0] OP_PW      = 4'd5;
  localparam logic [3:0] OP_PA      = 4'd6;
  localparam logic [3:0] OP_RW      = 4'd7;
  localparam logic [3:0] OP_RA      = 4'd8;

  localparam logic [2:0] PRE_LAST   = 3'd5;
  localparam logic [2:0] BLEND_LAST = 3'd4;

  localparam logic signed [PROD_W-1:0] G_HALF  = PROD_W'(2 ** (GS - 1));
  localparam logic signed [SUM_W-1:0]  B_HALF  = SUM_W'(2 ** (BLEND_SH - 1));
  localparam logic signed [SUM_W-1:0]  ANG_MAX = SUM_W'(2 ** (ANG_W - 1) - 1);
  localparam logic signed [SUM_W-1:0]  ANG_MIN = -SUM_W'(2 ** (ANG_W - 1));

  logic [2:0]               state;
  logic [2:0]               cnt;
  logic                     ang_go;

  logic [GAIN_W-1:0]        gain;
  logic [WEIGHT_W-1:0]      weight;

  logic signed [IN_W-1:0]   ax;
  logic signed [IN_W-1:0]   ay;
  logic signed [IN_W-1:0]   az;
  logic signed [IN_W-1:0]   gx;
  logic signed [IN_W-1:0]   gy;

  logic signed [ANG_W-1:0]  pitch_est;
  logic signed [ANG_W-1:0]  roll_est;
  logic signed [PRED_W-1:0] pitch_pred;
  logic signed [PRED_W-1:0] roll_pred;
  logic signed [ACC_W-1:0]  pitch_acc;
  logic signed [ACC_W-1:0]  roll_acc;
  logic [SQ_W-2:0]          sq_x;
  logic [SQ_W-2:0]          sq_y;
  logic [SQ_W-2:0]          sq_z;
  logic                     sat_p;
  logic                     sat_r;

  logic signed [PROD_W-1:0] prod;
  logic [3:0]               prod_tag;
  logic                     prod_vld;
  logic signed [PROD_W-1:0] blend_acc;

  logic                     out_valid;
  logic signed [ANG_W-1:0]  out_pitch;
  logic signed [ANG_W-1:0]  out_roll;
  logic                     out_sat;

  logic                     mul_go;
  logic [3:0]               mul_op;
  logic signed [MA_W-1:0]   op_a;
  logic signed [MB_W-1:0]   op_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [WEIGHT_W-1:0]      w_cl;
  logic [WEIGHT_W-1:0]      w_acc;
  logic signed [PROD_W-1:0] g_rnd;
  logic signed [INC_W-1:0]  g_inc;
  logic signed [SUM_W-1:0]  b_sum;
  logic signed [SUM_W-1:0]  b_v;
  logic signed [ANG_W-1:0]  b_val;
  logic                     b_sat;
  logic [SQ_W-1:0]          sq_sum;
  logic                     in_take;
  logic                     out_load;

  ang_ctl_t                 ang_ctl;
  ang_sts_t                 ang_sts;
  logic [SQ_IN_W-1:0]       ang_rad;
  logic signed [IN_W-1:0]   ang_num;
  logic signed [ACC_W-1:0]  ang_angle;

  assign in_take  = samples.valid && samples.ready;
  assign out_load = (state == S_OUT) && (!out_valid || angles.ready);

  // Configuration writes; unknown indexes drop
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GAIN_RESET;
      weight <= WEIGHT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_GYRO_STEP_GAIN) begin
        gain <= cfg.data;
      end else if (cfg.index == REG_GYRO_WEIGHT) begin
        weight <= cfg.data[WEIGHT_W-1:0];
      end
    end
  end

  // Clamp the gyro weight to one
  assign w_cl  = weight[WEIGHT_W-1] ? WEIGHT_ONE : weight;
  assign w_acc = WEIGHT_ONE - w_cl;

  // Pick the multiplier operation for this cycle
  always_comb begin
    mul_go = 1'b0;
    mul_op = OP_GY_GAIN;
    if (state == S_PRE) begin
      mul_go = (cnt != PRE_LAST);
      unique case (cnt)
        3'd0:    mul_op = OP_GY_GAIN;
        3'd1:    mul_op = OP_GX_GAIN;
        3'd2:    mul_op = OP_AX_SQ;
        3'd3:    mul_op = OP_AY_SQ;
        default: mul_op = OP_AZ_SQ;
      endcase
    end else if (state == S_BLEND) begin
      mul_go = (cnt != BLEND_LAST);
      unique case (cnt)
        3'd0:    mul_op = OP_PW;
        3'd1:    mul_op = OP_PA;
        3'd2:    mul_op = OP_RW;
        default: mul_op = OP_RA;
      endcase
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    unique case (mul_op)
      OP_GY_GAIN: begin
        op_a = MA_W'(gy);
        op_b = $signed({1'b0, gain});
      end
      OP_GX_GAIN: begin
        op_a = MA_W'(gx);
        op_b = $signed({1'b0, gain});
      end
      OP_AX_SQ: begin
        op_a = MA_W'(ax);
        op_b = MB_W'(ax);
      end
      OP_AY_SQ: begin
        op_a = MA_W'(ay);
        op_b = MB_W'(ay);
      end
      OP_AZ_SQ: begin
        op_a = MA_W'(az);
        op_b = MB_W'(az);
      end
      OP_PW: begin
        op_a = MA_W'(pitch_pred);
        op_b = $signed(MB_W'(w_cl));
      end
      OP_PA: begin
        op_a = MA_W'(pitch_acc);
        op_b = $signed(MB_W'(w_acc));
      end
      OP_RW: begin
        op_a = MA_W'(roll_pred);
        op_b = $signed(MB_W'(w_cl));
      end
      OP_RA: begin
        op_a = MA_W'(roll_acc);
        op_b = $signed(MB_W'(w_acc));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    mul_p = PROD_W'(op_a) * PROD_W'(op_b);
  end

  // Register the product with its operation tag
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= mul_go;
    end
    prod     <= mul_p;
    prod_tag <= mul_op;
  end

  // Round the gyro product; finish the blend with clipping
  always_comb begin
    g_rnd = prod + G_HALF;
    g_inc = INC_W'(g_rnd >>> GS);
    b_sum = SUM_W'(blend_acc) + SUM_W'(prod) + B_HALF;
    b_v   = b_sum >>> BLEND_SH;
    b_sat = 1'b1;
    if (b_v > ANG_MAX) begin
      b_val = ANG_MAX[ANG_W-1:0];
    end else if (b_v < ANG_MIN) begin
      b_val = ANG_MIN[ANG_W-1:0];
    end else begin
      b_val = b_v[ANG_W-1:0];
      b_sat = 1'b0;
    end
  end

  // Consume products by tag
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_est <= '0;
      roll_est  <= '0;
    end else if (prod_vld) begin
      unique case (prod_tag)
        OP_GY_GAIN: pitch_pred <= PRED_W'(pitch_est) + PRED_W'(g_inc);
        OP_GX_GAIN: roll_pred  <= PRED_W'(roll_est) + PRED_W'(g_inc);
        OP_AX_SQ:   sq_x       <= prod[SQ_W-2:0];
        OP_AY_SQ:   sq_y       <= prod[SQ_W-2:0];
        OP_AZ_SQ:   sq_z       <= prod[SQ_W-2:0];
        OP_PW:      blend_acc  <= prod;
        OP_PA: begin
          pitch_est <= b_val;
          sat_p     <= b_sat;
        end
        OP_RW:      blend_acc  <= prod;
        OP_RA: begin
          roll_est <= b_val;
          sat_r    <= b_sat;
        end
        default: ;
      endcase
    end
  end

  // Feed the angle unit with pitch or roll operands
  always_comb begin
    if (state == S_ANG_R) begin
      sq_sum  = SQ_W'(sq_y) + SQ_W'(sq_z);
      ang_num = ax;
    end else begin
      sq_sum  = SQ_W'(sq_x) + SQ_W'(sq_z);
      ang_num = ay;
    end
    ang_rad       = {sq_sum, {RAD_SH{1'b0}}};
    ang_ctl.start = ang_go;
  end

  itcf_angle u_angle (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ang_ctl),
    .radicand (ang_rad),
    .num      (ang_num),
    .sts      (ang_sts),
    .angle    (ang_angle)
  );

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      ang_go <= 1'b0;
    end else begin
      ang_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            ax    <= samples.accel_x;
            ay    <= samples.accel_y;
            az    <= samples.accel_z;
            gx    <= samples.gyro_x;
            gy    <= samples.gyro_y;
            cnt   <= '0;
            state <= S_PRE;
          end
        end
        S_PRE: begin
          cnt <= cnt + 1'b1;
          if (cnt == PRE_LAST) begin
            cnt    <= '0;
            ang_go <= 1'b1;
            state  <= S_ANG_P;
          end
        end
        S_ANG_P: begin
          if (ang_sts.done) begin
            pitch_acc <= ang_angle;
            ang_go    <= 1'b1;
            state     <= S_ANG_R;
          end
        end
        S_ANG_R: begin
          if (ang_sts.done) begin
            roll_acc <= ang_angle;
            cnt      <= '0;
            state    <= S_BLEND;
          end
        end
        S_BLEND: begin
          cnt <= cnt + 1'b1;
          if (cnt == BLEND_LAST) begin
            cnt   <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (angles.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_pitch <= pitch_est;
      out_roll  <= roll_est;
      out_sat   <= sat_p | sat_r;
    end
  end

  assign samples.ready      = (state == S_IDLE);
  assign angles.valid       = out_valid;
  assign angles.pitch_angle = out_pitch;
  assign angles.roll_angle  = out_roll;
  assign angles.saturated   = out_sat;

  // Checks on sequencer and angle unit cooperation
  `ITCF_ASSERT_IMP(a_ang_start_idle, clk, rst, ang_ctl.start, !ang_sts.busy, "angle unit started while busy")
  `ITCF_ASSERT_IMP(a_ang_done_wait, clk, rst, ang_sts.done, state == S_ANG_P || state == S_ANG_R, "angle result outside wait state")
  `ITCF_ASSERT_IMP(a_prod_phase, clk, rst, prod_vld, state == S_PRE || state == S_BLEND, "product outside multiply phase")
  `ITCF_ASSERT_NXT(a_busy_after_take, clk, rst, in_take, !samples.ready, "ready after sample taken")

endmodule

`default_nettype wire
